>>> rtl/core/sacl_pkg.sv
package sacl_pkg;

    localparam int NUM_SETS        = 16;
    localparam int WAYS            = 4;
    localparam int WORDS_PER_BLOCK = 4;
    localparam int TAG_BITS        = 26;
    localparam int COUNT_BITS      = 16;
    localparam int ADDR_BITS       = 32;

    localparam int OFS_BITS  = $clog2(WORDS_PER_BLOCK);
    localparam int SETF_BITS = $clog2(NUM_SETS);
    localparam int SHIFT     = OFS_BITS + SETF_BITS;
    localparam int SET_W     = 4;
    localparam int WAY_W     = 2;
    localparam int FILL_W    = $clog2(WAYS + 1);
    localparam int LFSR_W    = 16;
    localparam int DATA_W    = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [LFSR_W-1:0]     LFSR_SEED  = 16'hACE1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [REG_IDX_W-1:0]  REG_POLICY = '0;
    localparam logic                  POLICY_LFU = 1'b1;

    typedef logic [SETF_BITS-1:0]  set_t;
    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [FILL_W-1:0]     fill_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // The set field wraps into range when NUM_SETS is not a power of two.
    function automatic set_t set_of(input logic [ADDR_BITS-1:0] a);
        logic [SETF_BITS:0] raw;
        raw = {1'b0, a[OFS_BITS +: SETF_BITS]};
        if (raw >= (SETF_BITS + 1)'(NUM_SETS)) begin
            raw = raw - (SETF_BITS + 1)'(NUM_SETS);
        end
        return raw[SETF_BITS-1:0];
    endfunction

    function automatic tag_t tag_of(input logic [ADDR_BITS-1:0] a);
        logic [63:0] wide;
        wide = 64'(a) >> SHIFT;
        return wide[TAG_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/sacl_ram.sv
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/sacl_ctrl.sv
module sacl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sacl_pkg::stat_t     stat,
    output sacl_pkg::cmd_t      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t state_reg;

    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && aresetn;
        cmd.load   = (state_reg == ST_IDLE) && aresetn && s_valid;
        cmd.commit = (state_reg == ST_LOOK) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/sacl_datapath.sv
module sacl_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sacl_pkg::cmd_t                        cmd,
    output sacl_pkg::stat_t                       stat,
    input  logic [sacl_pkg::ADDR_BITS-1:0]        s_address,
    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,
    output logic                                  policy,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_hit,
    output logic [sacl_pkg::SET_W-1:0]            m_set_index,
    output logic [sacl_pkg::WAY_W-1:0]            m_way,
    output logic                                  m_evicted
);

    localparam int TROW_W = sacl_pkg::WAYS * sacl_pkg::TAG_BITS;
    localparam int UROW_W = sacl_pkg::WAYS * sacl_pkg::COUNT_BITS;

    logic [sacl_pkg::ADDR_BITS-1:0]  addr_reg;
    logic                            policy_reg;
    logic [sacl_pkg::LFSR_W-1:0]     lfsr_reg;
    logic [sacl_pkg::WAYS-1:0]       valid_reg [sacl_pkg::NUM_SETS];
    sacl_pkg::fill_t                 fill_reg  [sacl_pkg::NUM_SETS];
    logic                            m_valid_reg;
    logic                            m_hit_reg;
    logic [sacl_pkg::SET_W-1:0]      m_set_index_reg;
    logic [sacl_pkg::WAY_W-1:0]      m_way_reg;
    logic                            m_evicted_reg;

    sacl_pkg::set_t                  set_cur;
    sacl_pkg::set_t                  set_rd;
    sacl_pkg::tag_t                  tag_cur;
    logic [TROW_W-1:0]               trow_rdata;
    logic [UROW_W-1:0]               urow_rdata;
    logic [sacl_pkg::WAYS-1:0][sacl_pkg::TAG_BITS-1:0]   tag_row;
    logic [sacl_pkg::WAYS-1:0][sacl_pkg::TAG_BITS-1:0]   tag_row_next;
    logic [sacl_pkg::WAYS-1:0][sacl_pkg::COUNT_BITS-1:0] use_row;
    logic [sacl_pkg::WAYS-1:0][sacl_pkg::COUNT_BITS-1:0] use_row_next;
    logic                            hit;
    logic [sacl_pkg::WAY_W-1:0]      hit_way;
    logic [sacl_pkg::WAY_W-1:0]      lfu_way;
    logic [sacl_pkg::WAY_W-1:0]      way_sel;
    logic                            set_full;
    logic                            evicted;
    logic                            lfsr_step_en;
    logic                            lfsr_fb;
    logic [sacl_pkg::LFSR_W-1:0]     lfsr_next;

    assign set_cur = sacl_pkg::set_of(addr_reg);
    assign tag_cur = sacl_pkg::tag_of(addr_reg);
    assign set_rd  = sacl_pkg::set_of(s_address);

    sacl_ram #(
        .WIDTH (TROW_W),
        .DEPTH (sacl_pkg::NUM_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (set_cur),
        .wdata (tag_row_next),
        .re    (cmd.load),
        .raddr (set_rd),
        .rdata (trow_rdata)
    );

    sacl_ram #(
        .WIDTH (UROW_W),
        .DEPTH (sacl_pkg::NUM_SETS)
    ) u_use_ram (
        .aclk  (aclk),
        .we    (cmd.commit),
        .waddr (set_cur),
        .wdata (use_row_next),
        .re    (cmd.load),
        .raddr (set_rd),
        .rdata (urow_rdata)
    );

    // A set that was never accessed has a fill count of zero, and its use counters
    // read as zero until the first access writes the row.
    always_comb begin
        tag_row = trow_rdata;
        if (fill_reg[set_cur] == '0) begin
            use_row = '0;
        end else begin
            use_row = urow_rdata;
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
            if (valid_reg[set_cur][w] && (tag_row[w] == tag_cur)) begin
                hit     = 1'b1;
                hit_way = sacl_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        lfu_way = '0;
        for (int w = 1; w < sacl_pkg::WAYS; w++) begin
            if (use_row[w] < use_row[lfu_way]) begin
                lfu_way = sacl_pkg::WAY_W'(w);
            end
        end
    end

    assign lfsr_fb   = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_next = {lfsr_fb, lfsr_reg[sacl_pkg::LFSR_W-1:1]};
    assign set_full  = (fill_reg[set_cur] == sacl_pkg::FILL_W'(sacl_pkg::WAYS));

    always_comb begin
        if (hit) begin
            way_sel = hit_way;
        end else if (!set_full) begin
            way_sel = fill_reg[set_cur][sacl_pkg::WAY_W-1:0];
        end else if (policy_reg == sacl_pkg::POLICY_LFU) begin
            way_sel = lfu_way;
        end else begin
            way_sel = lfsr_next[sacl_pkg::WAY_W-1:0];
        end
    end

    assign evicted      = !hit && set_full && valid_reg[set_cur][way_sel];
    assign lfsr_step_en = !hit && set_full && (policy_reg != sacl_pkg::POLICY_LFU);

    always_comb begin
        tag_row_next          = tag_row;
        tag_row_next[way_sel] = tag_cur;
        use_row_next          = use_row;
        if (use_row[way_sel] != sacl_pkg::COUNT_MAX) begin
            use_row_next[way_sel] = use_row[way_sel] + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg  <= 1'b0;
            lfsr_reg    <= sacl_pkg::LFSR_SEED;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < sacl_pkg::NUM_SETS; s++) begin
                valid_reg[s] <= '0;
                fill_reg[s]  <= '0;
            end
        end else begin
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                valid_reg[set_cur][way_sel] <= 1'b1;
                if (!hit && !set_full) begin
                    fill_reg[set_cur] <= fill_reg[set_cur] + 1'b1;
                end
                if (lfsr_step_en) begin
                    lfsr_reg <= lfsr_next;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_address;
        end
        if (cmd.commit) begin
            m_hit_reg       <= hit;
            m_set_index_reg <= sacl_pkg::SET_W'(set_cur);
            m_way_reg       <= way_sel;
            m_evicted_reg   <= evicted;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign policy        = policy_reg;
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_set_index   = m_set_index_reg;
    assign m_way         = m_way_reg;
    assign m_evicted     = m_evicted_reg;

endmodule

>>> rtl/core/set_assoc_cache_lookup.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_address
// m_        out        m_valid / m_ready  m_hit, m_set_index, m_way, m_evicted
// apb       in         psel / penable     paddr, pwdata, pwrite -> prdata, pready
//
// ST_IDLE reads the tag and use-count rows of an item's set from the two set-wide RAMs;
// ST_LOOK then compares, picks the way and writes the rows back.
// Reset is synchronous and active low; it clears the valid bits, fill counts, LFSR and
// policy register at once, so no clearing pass is needed.
// A result held in the output register stalls the write-back cycle until it is taken.
module set_assoc_cache_lookup (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sacl_pkg::ADDR_BITS-1:0]      s_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [sacl_pkg::SET_W-1:0]          m_set_index,
    output logic [sacl_pkg::WAY_W-1:0]          m_way,
    output logic                                m_evicted,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sacl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sacl_pkg::DATA_W-1:0]         pwdata,
    output logic [sacl_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    sacl_pkg::cmd_t                  cmd;
    sacl_pkg::stat_t                 stat;
    logic [sacl_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            cfg_we;
    logic                            policy;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sacl_pkg::APB_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == sacl_pkg::REG_POLICY);

    always_comb begin
        if (reg_idx == sacl_pkg::REG_POLICY) begin
            prdata = sacl_pkg::DATA_W'(policy);
        end else begin
            prdata = '0;
        end
    end

    sacl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sacl_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_address   (s_address),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[0]),
        .policy      (policy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_set_index (m_set_index),
        .m_way       (m_way),
        .m_evicted   (m_evicted)
    );

endmodule

>>> tb/sv/lookup_checker.sv
`timescale 1ns / 1ps

module lookup_checker
    import sacl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [ADDR_BITS-1:0]  s_address,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_hit,
    input  logic [SET_W-1:0]      m_set_index,
    input  logic [WAY_W-1:0]      m_way,
    input  logic                  m_evicted,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    input  logic [DATA_W-1:0]     prdata,
    output int                    errors,
    output int                    pending,
    output int                    lookups,
    output int                    hits,
    output int                    evictions
);

    localparam int LINES = NUM_SETS * WAYS;

    typedef struct packed {
        logic             hit;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way;
        logic             evicted;
    } lookup_t;

    tag_t              tag_mem [LINES];
    logic              line_ok [LINES];
    count_t            uses [LINES];
    int                fill_level [NUM_SETS];
    logic [LFSR_W-1:0] lfsr;
    logic              policy;
    lookup_t           lookups_due [$];

    task automatic report_mismatch(input string msg);
        if (errors < 40) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic compare_field(input string field, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("lookup %0d %s got %0d expected %0d",
                                      lookups, field, got, want));
        end
    endtask

    function automatic lookup_t predict_lookup(input logic [ADDR_BITS-1:0] a);
        lookup_t r;
        tag_t    t;
        int      s;
        int      base;
        int      w;
        int      pick;
        s    = int'(a[OFS_BITS +: SETF_BITS]) % NUM_SETS;
        t    = tag_t'(a >> SHIFT);
        base = s * WAYS;
        r    = '0;
        pick = 0;
        r.set_index = SET_W'(s);
        for (w = WAYS - 1; w >= 0; w--) begin
            if (line_ok[base + w] && tag_mem[base + w] == t) begin
                r.hit = 1'b1;
                pick  = w;
            end
        end
        if (!r.hit) begin
            if (fill_level[s] < WAYS) begin
                pick = fill_level[s];
                fill_level[s]++;
            end else begin
                if (policy == POLICY_LFU) begin
                    pick = 0;
                    for (w = 1; w < WAYS; w++) begin
                        if (uses[base + w] < uses[base + pick]) begin
                            pick = w;
                        end
                    end
                end else begin
                    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
                    pick = int'(lfsr) % WAYS;
                end
                r.evicted = line_ok[base + pick];
            end
            tag_mem[base + pick] = t;
            line_ok[base + pick] = 1'b1;
        end
        if (uses[base + pick] != COUNT_MAX) begin
            uses[base + pick]++;
        end
        r.way = WAY_W'(pick);
        return r;
    endfunction

    always @(posedge aclk) begin
        lookup_t got;
        lookup_t want;
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                tag_mem[i] = '0;
                line_ok[i] = 1'b0;
                uses[i]    = '0;
            end
            for (int i = 0; i < NUM_SETS; i++) begin
                fill_level[i] = 0;
            end
            lfsr      = LFSR_SEED;
            policy    = ~POLICY_LFU;
            errors    = 0;
            lookups   = 0;
            hits      = 0;
            evictions = 0;
            lookups_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_hit, m_set_index, m_way, m_evicted};
                lookups++;
                hits      += m_hit;
                evictions += m_evicted;
                if (lookups_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no lookup pending",
                                              lookups));
                end else begin
                    want = lookups_due.pop_front();
                    compare_field("hit", got.hit, want.hit);
                    compare_field("set_index", got.set_index, want.set_index);
                    compare_field("way", got.way, want.way);
                    compare_field("evicted", got.evicted, want.evicted);
                end
            end
            if (s_valid && s_ready) begin
                lookups_due.push_back(predict_lookup(s_address));
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[APB_ADDR_W-1:2] == REG_POLICY && paddr[1:0] == 2'b00) begin
                        policy = pwdata[0];
                    end
                end else if (paddr == {REG_POLICY, 2'b00} && prdata !== DATA_W'(policy)) begin
                    report_mismatch($sformatf("policy read got %0h expected %0h",
                                              prdata, policy));
                end
            end
        end
        pending <= lookups_due.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sacl_pkg::*;

    localparam logic [APB_ADDR_W-1:0] POLICY_ADDR   = {REG_POLICY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR    = {~REG_POLICY, 2'b00};
    localparam logic                  POLICY_RANDOM = ~POLICY_LFU;
    localparam int                    POOL          = 6;
    localparam int                    HOT_HITS      = 12;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [ADDR_BITS-1:0]  s_address = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_hit;
    logic [SET_W-1:0]      m_set_index;
    logic [WAY_W-1:0]      m_way;
    logic                  m_evicted;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0]     pwdata    = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    int   fails;
    int   pending;
    int   lookups;
    int   hits;
    int   evictions;
    bit   quiet     = 1'b0;
    bit   long_hold = 1'b0;
    int   last_set  = 0;
    tag_t tag_pool [NUM_SETS][POOL];

    always #6 aclk = ~aclk;

    set_assoc_cache_lookup dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_address   (s_address),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_set_index (m_set_index),
        .m_way       (m_way),
        .m_evicted   (m_evicted),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lookup_checker lookup_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_address   (s_address),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_set_index (m_set_index),
        .m_way       (m_way),
        .m_evicted   (m_evicted),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .errors      (fails),
        .pending     (pending),
        .lookups     (lookups),
        .hits        (hits),
        .evictions   (evictions)
    );

    function automatic logic [ADDR_BITS-1:0] make_addr(input tag_t t, input int s);
        return {t, SETF_BITS'(s), OFS_BITS'($urandom)};
    endfunction

    task automatic offer(input logic [ADDR_BITS-1:0] a);
        int r;
        s_valid   <= 1'b1;
        s_address <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 60) begin
                s_valid <= 1'b0;
                repeat (r < 93 ? $urandom_range(1, 3) : $urandom_range(8, 25)) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int r;
        int s;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                offer($urandom);
            end else begin
                s = (r < 55) ? last_set : $urandom_range(0, NUM_SETS - 1);
                last_set = s;
                offer(make_addr(tag_pool[s][$urandom_range(0, POOL - 1)], s));
            end
        end
    endtask

    initial begin : receiver
        int stall;
        int r;
        bit hold_done;
        stall     = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                stall = 79;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    stall = (r < 3) ? $urandom_range(8, 30) : $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        tag_t hot;
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int k = 0; k < POOL; k++) begin
                tag_pool[s][k] = tag_t'($urandom);
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b1, POLICY_ADDR, DATA_W'(POLICY_RANDOM));
        apb_access(1'b0, POLICY_ADDR, '0);

        // A zero tag must not hit an empty line, and both address extremes are looked up.
        offer(32'h0000_0000);
        offer(32'h0000_0003);
        offer(32'hFFFF_FFFF);
        offer(32'hFFFF_FFFC);
        for (int k = 0; k < 7; k++) begin
            offer(make_addr(tag_t'(32'h155_5555 ^ k), 5));
        end
        offer(make_addr(tag_t'(32'h155_5555 ^ 6), 5));
        drain();

        apb_access(1'b1, POLICY_ADDR, ($urandom & ~32'h1) | DATA_W'(POLICY_LFU));
        apb_access(1'b0, POLICY_ADDR, '0);
        for (int k = 0; k < 4; k++) begin
            offer(make_addr(tag_t'(32'h2AA_AAAA ^ k), 9));
        end
        offer(make_addr(tag_t'(32'h2AA_AAAA), 9));
        offer(make_addr(tag_t'(32'h2AA_AAAA ^ 1), 9));
        offer(make_addr(tag_t'(32'h2AA_AAAA ^ 3), 9));
        offer(make_addr(tag_t'(32'h3FF_0000), 9));
        offer(make_addr(tag_t'(32'h3FF_0001), 9));
        offer(make_addr(tag_t'(32'h3FF_0002), 9));

        // Build up one heavily used line, then force LFU choices around it.
        quiet = 1'b1;
        hot = tag_t'($urandom);
        for (int k = 0; k < HOT_HITS; k++) begin
            offer(make_addr(hot, 12));
        end
        for (int k = 1; k < 8; k++) begin
            offer(make_addr(hot ^ tag_t'(k), 12));
        end
        offer(make_addr(hot, 12));
        quiet = 1'b0;
        drain();

        run_random(40);
        long_hold = 1'b1;
        quiet = 1'b1;
        run_random(30);
        quiet = 1'b0;
        run_random(90);
        drain();
        run_random(40);
        drain();

        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, POLICY_ADDR, '0);
        run_random(100);
        drain();

        apb_access(1'b1, POLICY_ADDR, ($urandom & ~32'h1) | DATA_W'(POLICY_RANDOM));
        apb_access(1'b0, POLICY_ADDR, '0);
        run_random(170);
        drain();

        apb_access(1'b1, POLICY_ADDR, 32'hFFFF_FFFF);
        apb_access(1'b0, POLICY_ADDR, '0);
        run_random(180);
        drain();
        repeat (20) @(posedge aclk);

        $display("Checked %0d lookups with %0d hits and %0d evictions.",
                 lookups, hits, evictions);
        $display("Both replacement policies, a heavily used line and stalls were exercised.");
        if (fails == 0) begin
            $display("set_assoc_cache_lookup regression: pass");
        end else begin
            $display("set_assoc_cache_lookup regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("set_assoc_cache_lookup regression: fail");
        $finish;
    end

endmodule
